### src/assert_macros.svh
// Assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold at every clock edge outside reset
`define CPD_ASSERT_IMPL(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that is active even during reset
`define CPD_ASSERT_ALWAYS(label, clk, cond, msg) \
   label: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

### src/cpd_pkg.sv
package cpd_pkg;

   localparam int MaxPoints = 1024;
   localparam int CoordBits = 24;
   localparam int AddrBits = $clog2(MaxPoints);
   localparam int CountBits = $clog2(MaxPoints + 1);
   localparam int SqBits = 49;
   localparam int DistBits = 41;
   localparam int DiffBits = CoordBits + 1;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_FEW = 2'd1;
   localparam logic [1:0] STATUS_DROP = 2'd2;

   localparam logic [SqBits-1:0] SqMax = {SqBits{1'b1}};

   typedef struct packed {
      logic signed [CoordBits-1:0] x_coord;
      logic signed [CoordBits-1:0] y_coord;
      logic last_point;
   } req_type;

   typedef struct packed {
      logic [SqBits-1:0] min_sq_distance;
      logic [DistBits-1:0] min_distance_fixed;
      logic [1:0] status;
   } rsp_type;

   // one command passed from front to back
   typedef struct packed {
      logic [CountBits-1:0] count;
      logic overflow;
   } job_type;

endpackage

### src/cpd_front.sv
module cpd_front
   import cpd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  req_type req_data,
   input  logic back_busy,
   output logic wr_en,
   output logic [AddrBits-1:0] wr_addr,
   output logic signed [CoordBits-1:0] wr_x,
   output logic signed [CoordBits-1:0] wr_y,
   output logic job_valid,
   input  logic job_ready,
   output job_type job
);

   logic [CountBits-1:0] count_ff, count_in;
   logic ovf_ff, ovf_in;
   logic pend_ff, pend_in;
   job_type job_ff, job_in;
   logic take, store;

   // the store is shared with the back part, so hold loading while a job is pending or the back part is busy
   assign req_ready = !pend_ff && !back_busy;
   assign take = req_valid && req_ready;
   assign store = take && (count_ff < CountBits'(MaxPoints));

   assign wr_en = store;
   assign wr_addr = count_ff[AddrBits-1:0];
   assign wr_x = req_data.x_coord;
   assign wr_y = req_data.y_coord;
   assign job_valid = pend_ff;
   assign job = job_ff;

   always_comb begin
      count_in = count_ff;
      ovf_in = ovf_ff;
      pend_in = pend_ff;
      job_in = job_ff;
      if (pend_ff && job_ready) begin
         pend_in = 1'b0;
      end
      if (take) begin
         if (store) begin
            count_in = count_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
         if (req_data.last_point) begin
            job_in.count = store ? count_ff + 1'b1 : count_ff;
            job_in.overflow = ovf_ff || !store;
            pend_in = 1'b1;
            count_in = '0;
            ovf_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff <= ovf_in;
         pend_ff <= pend_in;
      end
      job_ff <= job_in;
   end

endmodule

### src/cpd_back.sv
module cpd_back
   import cpd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic wr_en,
   input  logic [AddrBits-1:0] wr_addr,
   input  logic signed [CoordBits-1:0] wr_x,
   input  logic signed [CoordBits-1:0] wr_y,
   input  logic job_valid,
   output logic job_ready,
   input  job_type job,
   output logic busy,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rsp_type rsp_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RDI = 3'd1;
   localparam logic [2:0] S_RDJ = 3'd2;
   localparam logic [2:0] S_SQRT = 3'd3;
   localparam logic [2:0] S_OUT = 3'd4;

   logic [CoordBits-1:0] xmem [MaxPoints];
   logic [CoordBits-1:0] ymem [MaxPoints];
   logic signed [CoordBits-1:0] rd_x, rd_y;
   logic [AddrBits-1:0] rd_addr;

   logic [2:0] state_ff, state_in;
   logic [CountBits-1:0] n_ff, n_in, i_ff, i_in, j_ff, j_in;
   logic ovf_ff, ovf_in;
   logic signed [CoordBits-1:0] xi_ff, xi_in, yi_ff, yi_in;
   logic [SqBits-1:0] best_ff, best_in;
   logic rdv_ff, rdv_in;
   // pipeline: read -> diff -> square -> sum/compare
   logic d_v_ff;
   logic [DiffBits-1:0] dx_ff, dy_ff;
   logic m_v_ff;
   logic [2*DiffBits-1:0] sx_ff, sy_ff;
   logic [5:0] step_ff, step_in;
   logic [DistBits+1:0] rem_ff, rem_in;
   logic [DistBits-1:0] root_ff, root_in;
   rsp_type out_ff, out_in;
   logic signed [DiffBits-1:0] ddx, ddy;
   logic [2*DiffBits:0] sum;
   logic [SqBits-1:0] sq;
   logic [1:0] pair;
   logic [DistBits+1:0] rem_sh, trial;
   logic pipe_busy;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         xmem[wr_addr] <= wr_x;
         ymem[wr_addr] <= wr_y;
      end
      rd_x <= xmem[rd_addr];
      rd_y <= ymem[rd_addr];
   end

   assign busy = state_ff != S_IDLE;
   assign job_ready = state_ff == S_IDLE;
   assign rsp_valid = state_ff == S_OUT;
   assign rsp_data = out_ff;
   assign pipe_busy = rdv_ff || d_v_ff || m_v_ff;
   assign rd_addr = (state_ff == S_IDLE) ? '0 :
                    (state_ff == S_RDI) ? i_ff[AddrBits-1:0] : j_ff[AddrBits-1:0];

   assign ddx = DiffBits'(xi_ff) - DiffBits'(rd_x);
   assign ddy = DiffBits'(yi_ff) - DiffBits'(rd_y);
   assign sum = {1'b0, sx_ff} + {1'b0, sy_ff};
   assign sq = (sum > (2*DiffBits+1)'(SqMax)) ? SqMax : sum[SqBits-1:0];
   assign pair = (step_ff >= 6'd16) ? 2'(best_ff >> (2*step_ff - 7'd32)) : 2'b00;
   assign rem_sh = {rem_ff[DistBits-1:0], pair};
   assign trial = {root_ff, 2'b01};

   always_comb begin
      state_in = state_ff;
      n_in = n_ff;
      i_in = i_ff;
      j_in = j_ff;
      ovf_in = ovf_ff;
      xi_in = xi_ff;
      yi_in = yi_ff;
      best_in = best_ff;
      rdv_in = 1'b0;
      step_in = step_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      out_in = out_ff;
      if (m_v_ff && sq < best_ff) begin
         best_in = sq;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               n_in = job.count;
               ovf_in = job.overflow;
               best_in = SqMax;
               i_in = '0;
               if (job.count < CountBits'(2)) begin
                  out_in.min_sq_distance = '0;
                  out_in.min_distance_fixed = '0;
                  out_in.status = STATUS_FEW;
                  state_in = S_OUT;
               end else begin
                  state_in = S_RDI;
               end
            end
         end
         S_RDI: begin
            // address i is issued in this state; S_RDJ then captures its data as the row point
            j_in = i_ff + 1'b1;
            state_in = S_RDJ;
         end
         S_RDJ: begin
            if (j_ff == i_ff + 1'b1 && !rdv_ff) begin
               xi_in = rd_x;
               yi_in = rd_y;
            end
            if (j_ff < n_ff) begin
               rdv_in = 1'b1;
               j_in = j_ff + 1'b1;
            end else if (i_ff + CountBits'(2) < n_ff) begin
               i_in = i_ff + 1'b1;
               state_in = S_RDI;
            end else if (!pipe_busy) begin
               step_in = 6'(DistBits - 1);
               rem_in = '0;
               root_in = '0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if (rem_sh >= trial) begin
               rem_in = rem_sh - trial;
               root_in = {root_ff[DistBits-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               root_in = {root_ff[DistBits-2:0], 1'b0};
            end
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               out_in.min_sq_distance = best_ff;
               out_in.min_distance_fixed = root_in;
               out_in.status = ovf_ff ? STATUS_DROP : STATUS_OK;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rdv_ff <= 1'b0;
         d_v_ff <= 1'b0;
         m_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rdv_ff <= rdv_in;
         d_v_ff <= rdv_ff;
         m_v_ff <= d_v_ff;
      end
      n_ff <= n_in;
      i_ff <= i_in;
      j_ff <= j_in;
      ovf_ff <= ovf_in;
      xi_ff <= xi_in;
      yi_ff <= yi_in;
      best_ff <= best_in;
      step_ff <= step_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      out_ff <= out_in;
      dx_ff <= ddx[DiffBits-1] ? DiffBits'(-ddx) : DiffBits'(ddx);
      dy_ff <= ddy[DiffBits-1] ? DiffBits'(-ddy) : DiffBits'(ddy);
      sx_ff <= dx_ff * dx_ff;
      sy_ff <= dy_ff * dy_ff;
   end

endmodule

### src/closest_pair_distance.sv
// channel   dir   handshake            payload
// req       in    req_valid/req_ready  req_data (x, y, last point)
// rsp       out   rsp_valid/rsp_ready  rsp_data (sq dist, fixed dist, status)
// Loading takes one cycle per point while the compare unit is idle.
// After its last point, a set is compared one stored pair per cycle through the
// single store read port, with an S_RDI step at the start of each row, and then
// the digit-serial square root runs.
// Synchronous reset clears control; point storage is not cleared.
// Loading stalls while a set is being compared and while its rsp waits in a register.
module closest_pair_distance
   import cpd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rsp_type rsp_data
);

   logic wr_en, job_valid, job_ready, back_busy;
   logic [AddrBits-1:0] wr_addr;
   logic signed [CoordBits-1:0] wr_x, wr_y;
   job_type job;

   cpd_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_data(req_data), .back_busy(back_busy), .wr_en(wr_en), .wr_addr(wr_addr),
      .wr_x(wr_x), .wr_y(wr_y), .job_valid(job_valid), .job_ready(job_ready), .job(job)
   );

   cpd_back u_back (
      .clock(clock), .reset(reset), .wr_en(wr_en), .wr_addr(wr_addr), .wr_x(wr_x),
      .wr_y(wr_y), .job_valid(job_valid), .job_ready(job_ready), .job(job),
      .busy(back_busy), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

endmodule

### src/cpd_checker.sv
`include "assert_macros.svh"
module cpd_checker
   import cpd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  req_type req_data,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  rsp_type rsp_data
);

   logic rsp_stall, last_take, few_rsp;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign last_take = req_valid && req_ready && req_data.last_point;
   assign few_rsp = rsp_valid && rsp_data.status == STATUS_FEW;

   `CPD_ASSERT_IMPL(a_few_zero, clock, reset, few_rsp |-> (rsp_data.min_sq_distance == '0), "few")
   `CPD_ASSERT_IMPL(a_rsp_hold, clock, reset, rsp_stall |=> (rsp_valid && $stable(rsp_data)), "rsp")
   `CPD_ASSERT_IMPL(a_reset_idle, clock, reset, $past(reset) |-> !rsp_valid, "rsp after reset")
   `CPD_ASSERT_IMPL(a_last_holds, clock, reset, last_take |=> !req_ready, "req after last point")
   `CPD_ASSERT_ALWAYS(a_rsp_blocks_req, clock, rsp_valid |-> !req_ready, "req during rsp")

endmodule

bind closest_pair_distance cpd_checker u_checker (.*);

### dv/closest_pair_checker.sv
`timescale 1ns / 100ps

module closest_pair_checker
   import cpd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  req_type req_data,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  rsp_type rsp_data,
   output int mismatch_count,
   output int pending_count,
   output int result_count
);

   longint set_x[MaxPoints];
   longint set_y[MaxPoints];
   int stored_points;
   logic points_dropped;
   rsp_type expected_results[$];

   function automatic logic [DistBits-1:0] root_fixed(input logic [SqBits-1:0] sq);
      logic [DistBits-1:0] root;
      logic [DistBits-1:0] trial;
      logic [81:0] target;
      logic [81:0] trial_sq;
      root = '0;
      target = {sq, 32'b0};
      for (int b = DistBits - 1; b >= 0; b--) begin
         trial = root | (41'd1 << b);
         trial_sq = {41'b0, trial} * {41'b0, trial};
         if (trial_sq <= target) root = trial;
      end
      return root;
   endfunction

   function automatic rsp_type close_set();
      rsp_type r;
      longint best;
      longint dx;
      longint dy;
      longint sq;
      best = longint'(SqMax);
      if (stored_points < 2) begin
         r.min_sq_distance = '0;
         r.min_distance_fixed = '0;
         r.status = STATUS_FEW;
         return r;
      end
      for (int i = 0; i < stored_points; i++)
         for (int j = i + 1; j < stored_points; j++) begin
            dx = set_x[i] - set_x[j];
            dy = set_y[i] - set_y[j];
            sq = dx * dx + dy * dy;
            if (sq > longint'(SqMax)) sq = longint'(SqMax);
            if (sq < best) best = sq;
         end
      r.min_sq_distance = best[SqBits-1:0];
      r.min_distance_fixed = root_fixed(best[SqBits-1:0]);
      r.status = points_dropped ? STATUS_DROP : STATUS_OK;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      int errs;
      errs = 0;
      if (reset) begin
         stored_points = 0;
         points_dropped = 1'b0;
         mismatch_count <= 0;
         result_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            if (stored_points < MaxPoints) begin
               set_x[stored_points] = longint'(req_data.x_coord);
               set_y[stored_points] = longint'(req_data.y_coord);
               stored_points++;
            end else begin
               points_dropped = 1'b1;
            end
            if (req_data.last_point) begin
               expected_results = {expected_results, close_set()};
               stored_points = 0;
               points_dropped = 1'b0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            result_count <= result_count + 1;
            if (expected_results.size() == 0) begin
               $error("unexpected response: sq %0d", rsp_data.min_sq_distance);
               errs++;
            end else begin
               want = expected_results.pop_front();
               if (want.min_sq_distance !== rsp_data.min_sq_distance) begin
                  $error("min_sq_distance: expected %0d, got %0d",
                         want.min_sq_distance, rsp_data.min_sq_distance);
                  errs++;
               end
               if (want.min_distance_fixed !== rsp_data.min_distance_fixed) begin
                  $error("min_distance_fixed: expected %0d, got %0d",
                         want.min_distance_fixed, rsp_data.min_distance_fixed);
                  errs++;
               end
               if (want.status !== rsp_data.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  errs++;
               end
            end
         end
         mismatch_count <= mismatch_count + errs;
      end
      pending_count <= expected_results.size();
   end

endmodule

### dv/closest_pair_distance_test.sv
`timescale 1ns / 100ps

module closest_pair_distance_test;
   import cpd_pkg::*;

   localparam int WatchdogLimit = 3_000_000;
   localparam logic signed [23:0] CoordMin = -24'sd8388608;
   localparam logic signed [23:0] CoordMax = 24'sd8388607;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;

   int mismatch_count;
   int pending_count;
   int result_count;
   int set_count = 0;
   int point_count = 0;
   int idle_cycles = 0;
   logic quiet = 1'b0;
   int stall_left = 0;

   closest_pair_distance dut (.*);

   closest_pair_checker checker_i (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .mismatch_count, .pending_count, .result_count
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hold off responses in short random bursts, with calm stretches between
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 6);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("closest_pair_distance regression: fail");
         $finish;
      end
   end

   task automatic send_point(input logic signed [23:0] x, input logic signed [23:0] y,
                             input logic last);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{x_coord: x, y_coord: y, last_point: last};
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      point_count++;
      if (last) set_count++;
   endtask

   function automatic logic signed [23:0] rand_coord(input bit narrow);
      if (narrow) return 24'(signed'($urandom_range(0, 64)) - 32);
      case ($urandom_range(0, 9))
         0: return CoordMin;
         1: return CoordMax;
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic send_set(input int size, input bit narrow);
      for (int i = 0; i < size; i++)
         send_point(rand_coord(narrow), rand_coord(narrow), i == size - 1);
   endtask

   initial begin
      int sent;
      int size;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // lone point: too few for a pair
      send_point(CoordMin, CoordMax, 1'b1);
      // opposite corners: widest distance
      send_point(CoordMin, CoordMin, 1'b0);
      send_point(CoordMax, CoordMax, 1'b1);
      // coincident points give zero
      send_point(24'sd5, -24'sd7, 1'b0);
      send_point(24'sd100, 24'sd100, 1'b0);
      send_point(24'sd5, -24'sd7, 1'b1);
      // alternating bit patterns and unit steps
      send_point(24'h555555, 24'haaaaaa, 1'b0);
      send_point(24'haaaaaa, 24'h555555, 1'b0);
      send_point(24'sd0, 24'sd0, 1'b0);
      send_point(24'sd1, 24'sd1, 1'b1);
      send_point(-24'sd1, 24'sd0, 1'b0);
      send_point(24'sd0, 24'sd0, 1'b1);

      sent = 0;
      while (sent < 400) begin
         if (sent > 300) quiet = 1'b1;
         size = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 10);
         send_set(size, $urandom_range(0, 1));
         sent += size;
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Sent %0d points in %0d sets, corner and random coordinates;", point_count,
               set_count);
      $display("checked %0d responses.", result_count);
      if (mismatch_count == 0 && pending_count == 0)
         $display("closest_pair_distance regression: pass");
      else
         $display("closest_pair_distance regression: fail");
      $finish;
   end

endmodule

### closest_pair_distance.f
+incdir+src
src/cpd_pkg.sv
src/cpd_front.sv
src/cpd_back.sv
src/closest_pair_distance.sv
src/cpd_checker.sv
dv/closest_pair_checker.sv
dv/closest_pair_distance_test.sv
